// ----- rtl/core/llf_pkg.sv -----
// Package for the 3x3 Laplacian RGB filter: sizes, reset values, register
// indexes and the pixel and result word types. No dependencies.
package llf_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinDim    = 3;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;

  // counter and register widths
  localparam int unsigned ColW    = $clog2(MaxWidth);       // 11
  localparam int unsigned RowW    = $clog2(MaxHeight);      // 12
  localparam int unsigned WidthW  = 12;
  localparam int unsigned HeightW = 13;
  localparam int unsigned EffWW   = ColW + 1;
  localparam int unsigned EffHW   = RowW + 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

  localparam logic [WidthW-1:0]  ResetWidth  = 12'd640;
  localparam logic [HeightW-1:0] ResetHeight = 13'd480;

  // window slots: 0..2 column c-2 (up, mid, low), 3..5 column c-1
  localparam int unsigned WinDepth   = 6;
  localparam int unsigned WinLeftMid = 1;
  localparam int unsigned WinUp      = 3;
  localparam int unsigned WinMid     = 4;
  localparam int unsigned WinLow     = 5;

  // output queue
  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 2;

  // channel 2 is red, 1 green, 0 blue
  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
  } res_t;

endpackage

// ----- rtl/core/llf_stream_if.sv -----
// Valid/ready stream interfaces for pixel input and filtered result output.
// Uses the widths in llf_pkg.
interface llf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [llf_pkg::ChanW-1:0] in_red;
  logic [llf_pkg::ChanW-1:0] in_green;
  logic [llf_pkg::ChanW-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface llf_res_if;
  logic                      valid;
  logic                      ready;
  logic [llf_pkg::ChanW-1:0] out_red;
  logic [llf_pkg::ChanW-1:0] out_green;
  logic [llf_pkg::ChanW-1:0] out_blue;
  logic                      frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

// ----- rtl/core/laplacian_3x3_rgb_filter_top.sv -----
// Top level of the 3x3 Laplacian RGB filter: line stores, window, three
// channel lanes, result merge and output queue. Uses llf_pkg, llf_stream_if,
// llf_ram and llf_lane.
//
//   port     dir  handshake     word
//   pix_i    in   valid/ready   in_red, in_green, in_blue
//   res_o    out  valid/ready   out_red, out_green, out_blue, frame_end
//   cfg_*    in   write enable  index 0 image_width, 1 image_height
//
// One pixel per clock while the output queue has room. A result is valid once
// the pixel that completes it has passed the registered line store read and
// the lanes have pushed it into the three-word output queue.
// Reset clears counters and queue and loads the config reset values; line
// stores and window are not cleared, so no clearing pass is needed.
// pix_i.ready drops only when the output queue cannot absorb the words in flight.
module laplacian_3x3_rgb_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  llf_pix_if.sink                        pix_i,
  llf_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [llf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [llf_pkg::CfgDataW-1:0]   cfg_data_i
);

  // ---------------- configuration ----------------
  logic [llf_pkg::WidthW-1:0]  width_q;
  logic [llf_pkg::HeightW-1:0] height_q;
  logic [llf_pkg::EffWW-1:0]   w_eff;
  logic [llf_pkg::EffHW-1:0]   h_eff;
  logic                        cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == llf_pkg::CfgWidth ||
                                cfg_idx_i == llf_pkg::CfgHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= llf_pkg::ResetWidth;
      height_q <= llf_pkg::ResetHeight;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        llf_pkg::CfgWidth:  width_q  <= cfg_data_i[llf_pkg::WidthW-1:0];
        llf_pkg::CfgHeight: height_q <= cfg_data_i[llf_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < llf_pkg::WidthW'(llf_pkg::MinDim)) begin
      w_eff = llf_pkg::EffWW'(llf_pkg::MinDim);
    end else if (width_q > llf_pkg::WidthW'(llf_pkg::MaxWidth)) begin
      w_eff = llf_pkg::EffWW'(llf_pkg::MaxWidth);
    end else begin
      w_eff = llf_pkg::EffWW'(width_q);
    end
    if (height_q < llf_pkg::HeightW'(llf_pkg::MinDim)) begin
      h_eff = llf_pkg::EffHW'(llf_pkg::MinDim);
    end else if (height_q > llf_pkg::HeightW'(llf_pkg::MaxHeight)) begin
      h_eff = llf_pkg::EffHW'(llf_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------- position counters ----------------
  logic [llf_pkg::ColW-1:0] col_q, col_d;
  logic [llf_pkg::RowW-1:0] row_q, row_d;
  logic                     in_acc;
  logic                     in_ready;
  logic                     last_col, last_row, emit;

  assign in_acc   = pix_i.valid && in_ready;
  assign pix_i.ready = in_ready;

  assign last_col = ({1'b0, col_q} == w_eff - llf_pkg::EffWW'(1));
  assign last_row = ({1'b0, row_q} == h_eff - llf_pkg::EffHW'(1));
  assign emit     = (row_q >= llf_pkg::RowW'(2)) && (col_q >= llf_pkg::ColW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + llf_pkg::RowW'(1);
      end else begin
        col_d = col_q + llf_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- line stores ----------------
  llf_pkg::pix_t in_pix;
  llf_pkg::pix_t up_rd, mid_rd;

  assign in_pix = {pix_i.in_red, pix_i.in_green, pix_i.in_blue};

  // stage-1 registers: loaded when the pixel is taken
  logic                     s1_valid_q;
  logic                     s1_emit_q;
  logic                     s1_last_q;
  logic [llf_pkg::ColW-1:0] s1_col_q;
  llf_pkg::pix_t            s1_pix_q;

  // middle store: read old row r-1 and write the new pixel in the same cycle
  llf_ram #(
    .Width ($bits(llf_pkg::pix_t)),
    .Depth (llf_pkg::MaxWidth)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (in_pix),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // upper store: takes the old middle word once it has been read
  llf_ram #(
    .Width ($bits(llf_pkg::pix_t)),
    .Depth (llf_pkg::MaxWidth)
  ) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q <= emit;
      s1_last_q <= last_row && last_col;
      s1_col_q  <= col_q;
      s1_pix_q  <= in_pix;
    end
  end

  // ---------------- 3x3 window ----------------
  llf_pkg::pix_t win_q [llf_pkg::WinDepth];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= s1_pix_q;
    end
  end

  // ---------------- channel lanes and merge ----------------
  llf_pkg::pix_t lane_pix;
  llf_pkg::res_t merged;

  for (genvar ch = 0; ch < llf_pkg::NumChan; ch++) begin : g_lane
    llf_lane u_lane (
      .centre_i (win_q[llf_pkg::WinMid][ch]),
      .up_i     (win_q[llf_pkg::WinUp][ch]),
      .down_i   (win_q[llf_pkg::WinLow][ch]),
      .left_i   (win_q[llf_pkg::WinLeftMid][ch]),
      .right_i  (mid_rd[ch]),
      .pix_o    (lane_pix[ch])
    );
  end

  assign merged = '{red:       lane_pix[2],
                    green:     lane_pix[1],
                    blue:      lane_pix[0],
                    frame_end: s1_last_q};

  // ---------------- output queue ----------------
  llf_pkg::res_t                fifo_q [llf_pkg::FifoDepth];
  logic [llf_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [llf_pkg::FifoCntW-1:0] cnt_q;
  logic                         push, pop;
  logic [llf_pkg::FifoCntW:0]   pending;
  llf_pkg::res_t                head;

  assign push    = s1_valid_q && s1_emit_q;
  assign pop     = res_o.valid && res_o.ready;
  assign pending = {1'b0, cnt_q} + {{llf_pkg::FifoCntW{1'b0}}, push};
  // room for the word in stage 1 and the one taken now
  assign in_ready = (pending < (llf_pkg::FifoCntW+1)'(llf_pkg::FifoDepth));

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == llf_pkg::FifoPtrW'(llf_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + llf_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == llf_pkg::FifoPtrW'(llf_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + llf_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + llf_pkg::FifoCntW'(push) - llf_pkg::FifoCntW'(pop);
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign res_o.valid     = (cnt_q != '0);
  assign res_o.out_red   = head.red;
  assign res_o.out_green = head.green;
  assign res_o.out_blue  = head.blue;
  assign res_o.frame_end = head.frame_end;

  // ---------------- assertions ----------------
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != llf_pkg::FifoCntW'(llf_pkg::FifoDepth)) || pop)
    else $error("output queue overflow");

  a_s1_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(in_acc))
    else $error("stage 1 word without a taken pixel");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_col) |=> (col_q == '0))
    else $error("column counter did not wrap at end of row");

endmodule

// ----- rtl/core/llf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, read-first on a same-address collision. No dependencies.
module llf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/llf_lane.sv -----
// One channel lane: the quadrupled centre minus the up, down, left and right neighbors, clamped to 0..255.
// Uses llf_pkg for the channel width.
module llf_lane (
  input  logic [llf_pkg::ChanW-1:0] centre_i,
  input  logic [llf_pkg::ChanW-1:0] up_i,
  input  logic [llf_pkg::ChanW-1:0] down_i,
  input  logic [llf_pkg::ChanW-1:0] left_i,
  input  logic [llf_pkg::ChanW-1:0] right_i,
  output logic [llf_pkg::ChanW-1:0] pix_o
);

  // range -1020..1020 fits 11 bits signed
  logic signed [llf_pkg::ChanW+2:0] acc;

  always_comb begin
    acc = $signed({1'b0, centre_i, 2'b00})
        - $signed({3'b000, up_i})
        - $signed({3'b000, down_i})
        - $signed({3'b000, left_i})
        - $signed({3'b000, right_i});
    if (acc[llf_pkg::ChanW+2]) begin
      pix_o = '0;
    end else if (|acc[llf_pkg::ChanW+1:llf_pkg::ChanW]) begin
      pix_o = '1;
    end else begin
      pix_o = acc[llf_pkg::ChanW-1:0];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for laplacian_3x3_rgb_filter_top: pixel stream in, filtered words out,
// compared against a behavioral line-buffer predictor. Needs llf_pkg, llf_stream_if and the
// filter RTL.
module tb_top;
  import llf_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 12;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 380;
  localparam int unsigned MaxReported   = 10;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int unsigned ChRed   = 2;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 0;

  typedef enum int {StyleNoise, StyleSmooth, StyleExtreme} pix_style_e;

  typedef struct {
    pix_t px;
    bit   has_exp;
    res_t exp;
  } stim_row_t;

  localparam pix_t Blk = 24'h000000;
  localparam pix_t Wht = 24'hFFFFFF;
  localparam pix_t Crn = 24'h7B2D43;
  localparam pix_t Edg = 24'h00FF02;
  localparam pix_t Ctr = 24'hFF000A;

  localparam res_t NoRes   = '0;
  localparam res_t SatAll  = {8'd255, 8'd255, 8'd255, 1'b1};
  localparam res_t ZeroAll = {8'd0, 8'd0, 8'd0, 1'b1};
  localparam res_t Mixed   = {8'd255, 8'd0, 8'd32, 1'b1};

  // three 3x3 frames; only the center is interior, its word comes with the last pixel
  stim_row_t directed_rows [27] = '{
    '{Blk, 1'b0, NoRes}, '{Blk, 1'b0, NoRes}, '{Blk, 1'b0, NoRes},
    '{Blk, 1'b0, NoRes}, '{Wht, 1'b0, NoRes}, '{Blk, 1'b0, NoRes},
    '{Blk, 1'b0, NoRes}, '{Blk, 1'b0, NoRes}, '{Blk, 1'b1, SatAll},
    '{Wht, 1'b0, NoRes}, '{Wht, 1'b0, NoRes}, '{Wht, 1'b0, NoRes},
    '{Wht, 1'b0, NoRes}, '{Blk, 1'b0, NoRes}, '{Wht, 1'b0, NoRes},
    '{Wht, 1'b0, NoRes}, '{Wht, 1'b0, NoRes}, '{Wht, 1'b1, ZeroAll},
    '{Crn, 1'b0, NoRes}, '{Edg, 1'b0, NoRes}, '{Crn, 1'b0, NoRes},
    '{Edg, 1'b0, NoRes}, '{Ctr, 1'b0, NoRes}, '{Edg, 1'b0, NoRes},
    '{Crn, 1'b0, NoRes}, '{Edg, 1'b0, NoRes}, '{Crn, 1'b1, Mixed}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  llf_pix_if pix_if ();
  llf_res_if res_if ();

  laplacian_3x3_rgb_filter_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- predictor state ----
  pix_t               upper_line [MaxWidth];
  pix_t               middle_line [MaxWidth];
  pix_t               win_col [WinDepth];
  logic [WidthW-1:0]  frame_width  = ResetWidth;
  logic [HeightW-1:0] frame_height = ResetHeight;
  int unsigned        next_col = 0;
  int unsigned        next_row = 0;

  res_t        laplacian_due [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;

  // typed expectation riding along with the pixel on the wire
  bit   row_typed;
  res_t row_want;
  pix_t last_px = '0;
  int unsigned burst_left = 0;

  function automatic logic [ChanW-1:0] lap_chan(input logic [ChanW-1:0] ctr, up, dn, lf, rt);
    int v;
    v = 4 * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  function automatic bit compute_laplacian(input pix_t px, output res_t res);
    int unsigned w, h, c, r;
    pix_t up, mid;
    bit has;
    w = (frame_width < MinDim) ? MinDim : (frame_width > MaxWidth) ? MaxWidth : frame_width;
    h = (frame_height < MinDim) ? MinDim :
        (frame_height > MaxHeight) ? MaxHeight : frame_height;
    c = (next_col < w) ? next_col : w - 1;
    r = (next_row < h) ? next_row : h - 1;
    up  = upper_line[c];
    mid = middle_line[c];
    has = (r >= 2 && c >= 2);
    res = '0;
    if (has) begin
      res.red   = lap_chan(win_col[WinMid][ChRed], win_col[WinUp][ChRed],
                           win_col[WinLow][ChRed], win_col[WinLeftMid][ChRed], mid[ChRed]);
      res.green = lap_chan(win_col[WinMid][ChGreen], win_col[WinUp][ChGreen],
                           win_col[WinLow][ChGreen], win_col[WinLeftMid][ChGreen],
                           mid[ChGreen]);
      res.blue  = lap_chan(win_col[WinMid][ChBlue], win_col[WinUp][ChBlue],
                           win_col[WinLow][ChBlue], win_col[WinLeftMid][ChBlue], mid[ChBlue]);
      res.frame_end = (r == h - 1 && c == w - 1);
    end
    upper_line[c]  = mid;
    middle_line[c] = px;
    for (int s = 0; s < WinUp; s++) win_col[s] = win_col[s + WinUp];
    win_col[WinUp]  = up;
    win_col[WinMid] = mid;
    win_col[WinLow] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
    return has;
  endfunction

  // ---- monitor: result side first so a word can never match its own pixel's push ----
  always @(posedge clk) begin : monitor
    res_t got, want;
    bit   moved, has;
    moved = 1'b0;
    if (res_if.valid && res_if.ready) begin
      moved = 1'b1;
      got.red       = res_if.out_red;
      got.green     = res_if.out_green;
      got.blue      = res_if.out_blue;
      got.frame_end = res_if.frame_end;
      if (laplacian_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result word r=%0d g=%0d b=%0d end=%0d",
                   got.red, got.green, got.blue, got.frame_end);
      end else begin
        want = laplacian_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("result mismatch: exp r=%0d g=%0d b=%0d end=%0d,",
                     want.red, want.green, want.blue, want.frame_end,
                     " got r=%0d g=%0d b=%0d end=%0d",
                     got.red, got.green, got.blue, got.frame_end);
        end
      end
    end
    if (cfg_we) begin
      case (cfg_idx)
        CfgWidth: begin
          frame_width = cfg_data[WidthW-1:0];
          next_col = 0;
          next_row = 0;
        end
        CfgHeight: begin
          frame_height = cfg_data[HeightW-1:0];
          next_col = 0;
          next_row = 0;
        end
        default: ;
      endcase
    end
    if (pix_if.valid && pix_if.ready) begin
      moved = 1'b1;
      has = compute_laplacian({pix_if.in_red, pix_if.in_green, pix_if.in_blue}, want);
      if (row_typed) laplacian_due.push_back(row_want);
      else if (has) laplacian_due.push_back(want);
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // ---- receiver: stall pattern changes at random, one long hold-off ----
  initial begin : receiver
    int unsigned mode, left;
    bit held_off;
    res_if.ready = 1'b0;
    mode = 0;
    left = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && hold_off_req) begin
        held_off = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 1) != 0);
        2: res_if.ready <= ($urandom_range(0, 3) == 0);
        default: res_if.ready <= ((left % 8) < 5);
      endcase
    end
  end

  // ---- sender ----
  task automatic send_pixel(input pix_t px, input bit typed, input res_t want, input bit dense);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (!dense && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk);
        pix_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= px[ChRed];
    pix_if.in_green <= px[ChGreen];
    pix_if.in_blue  <= px[ChBlue];
    row_typed       <= typed;
    row_want        <= want;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic run_pixels(input int unsigned n, input pix_style_e style, input bit dense);
    pix_t px;
    int v;
    repeat (n) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        case (style)
          StyleExtreme: px[ch] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          StyleSmooth: begin
            // small steps keep most results away from the clamps
            v = int'(last_px[ch]) + int'($urandom_range(0, 16)) - 8;
            px[ch] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : ChanW'(v);
          end
          default: px[ch] = ChanW'($urandom);
        endcase
      end
      last_px = px;
      send_pixel(px, 1'b0, NoRes, dense);
    end
  endtask

  // pause the sender until every word is back, then let pixels without a word drain
  task automatic settle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (laplacian_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned npix, random_items;
    logic [CfgDataW-1:0] wdata, hdata;
    rst_n           = 1'b0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = '0;
    pix_if.in_green = '0;
    pix_if.in_blue  = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgWidth;
    cfg_data        = '0;
    row_typed       = 1'b0;
    row_want        = NoRes;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: a short burst stays in the first row and gives no word
    run_pixels(40, StyleNoise, 1'b0);
    settle();

    cfg_write(CfgWidth, CfgDataW'(3));
    cfg_write(CfgHeight, CfgDataW'(3));
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].has_exp, directed_rows[i].exp, 1'b0);
    settle();

    // undersized geometry is raised to 3x3
    cfg_write(CfgWidth, CfgDataW'(0));
    cfg_write(CfgHeight, CfgDataW'(0));
    run_pixels(30, StyleExtreme, 1'b0);
    settle();
    cfg_write(CfgWidth, CfgDataW'(1));
    cfg_write(CfgHeight, CfgDataW'(2));
    run_pixels(30, StyleNoise, 1'b1);
    settle();
    cfg_write(CfgWidth, CfgDataW'(2));
    cfg_write(CfgHeight, CfgDataW'(1));
    run_pixels(30, StyleSmooth, 1'b0);
    settle();

    // oversized width is cut to the line store depth
    cfg_write(CfgWidth, CfgDataW'(4095));
    cfg_write(CfgHeight, CfgDataW'(3));
    run_pixels(30, StyleNoise, 1'b0);
    settle();

    // oversized height on a narrow frame; the receiver holds off so the queue fills
    cfg_write(CfgWidth, CfgDataW'(3));
    cfg_write(CfgHeight, CfgDataW'(8191));
    hold_off_req = 1'b1;
    run_pixels(60, StyleNoise, 1'b1);
    settle();

    random_items = 0;
    while (random_items < RandomItems) begin
      wdata = {1'($urandom),
               12'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14))};
      hdata = 13'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10));
      case ($urandom_range(0, 5))
        // spare index: frame position must carry on
        0: cfg_write(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, CfgDataW'($urandom));
        1: cfg_write(CfgWidth, wdata);
        2: cfg_write(CfgHeight, hdata);
        default: begin
          cfg_write(CfgWidth, wdata);
          cfg_write(CfgHeight, hdata);
        end
      endcase
      npix = $urandom_range(10, 120);
      run_pixels(npix, pix_style_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
      settle();
      random_items += npix;
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && laplacian_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
